// ===== hw/rtl/cst_pkg.sv =====
// Shared types and constants for the comment skipping tokenizer.
// Used by cst_front, cst_queue, cst_back and the top level; no dependencies.
package cst_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int BUNDLE_MAX = 3;
   localparam int CNT_W = $clog2(BUNDLE_MAX + 1);

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] WHITE_MAX = 8'h20;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END = 1'b1;

   typedef enum logic [6:0] {
      MODE_IDLE       = 7'b0000001,
      MODE_SLASH      = 7'b0000010,
      MODE_TOKEN      = 7'b0000100,
      MODE_LINE       = 7'b0001000,
      MODE_LINE_CR    = 7'b0010000,
      MODE_BLOCK      = 7'b0100000,
      MODE_BLOCK_STAR = 7'b1000000
   } mode_type;

   // All results caused by one input byte.
   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [BUNDLE_MAX-1:0] kind;
      logic [BUNDLE_MAX-1:0][7:0] data;
   } bundle_type;

endpackage

// ===== hw/rtl/cst_front.sv =====
// Front end of the tokenizer: accepts text bytes, runs the lexer state
// machine and builds one result bundle per byte. Depends on cst_pkg.
module cst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_text_byte,
   input  logic              req_stream_end,
   input  logic              queue_full,
   output logic              push,
   output cst_pkg::bundle_type push_bundle
);
   import cst_pkg::*;

   mode_type mode_ff, mode_in, mode_nx;
   bundle_type bun;
   logic white, take;

   assign white = (req_text_byte != 8'h00) && (req_text_byte <= WHITE_MAX);
   assign req_ready = !queue_full;
   assign take = req_valid && req_ready;

   always_comb begin
      mode_nx = mode_ff;
      bun = '0;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (white) begin
               mode_nx = MODE_IDLE;
            end else if (req_text_byte == CH_SLASH) begin
               mode_nx = MODE_SLASH;
            end else begin
               bun.data[0] = req_text_byte;
               bun.cnt = CNT_W'(1);
               mode_nx = MODE_TOKEN;
            end
         end
         MODE_SLASH: begin
            if (req_text_byte == CH_SLASH) begin
               mode_nx = MODE_LINE;
            end else if (req_text_byte == CH_STAR) begin
               mode_nx = MODE_BLOCK;
            end else begin
               bun.data[0] = CH_SLASH;
               bun.cnt = CNT_W'(2);
               if (white) begin
                  bun.kind[1] = KIND_END;
                  mode_nx = MODE_IDLE;
               end else begin
                  bun.data[1] = req_text_byte;
                  mode_nx = MODE_TOKEN;
               end
            end
         end
         MODE_TOKEN: begin
            bun.cnt = CNT_W'(1);
            if (white) begin
               bun.kind[0] = KIND_END;
               mode_nx = MODE_IDLE;
            end else begin
               bun.data[0] = req_text_byte;
            end
         end
         MODE_LINE: begin
            if (req_text_byte == CH_CR) begin
               mode_nx = MODE_LINE_CR;
            end
         end
         MODE_LINE_CR: begin
            mode_nx = MODE_IDLE;
         end
         MODE_BLOCK: begin
            if (req_text_byte == CH_STAR) begin
               mode_nx = MODE_BLOCK_STAR;
            end
         end
         MODE_BLOCK_STAR: begin
            if (req_text_byte == CH_SLASH) begin
               mode_nx = MODE_IDLE;
            end else if (req_text_byte != CH_STAR) begin
               mode_nx = MODE_BLOCK;
            end
         end
         default: begin
            mode_nx = MODE_IDLE;
         end
      endcase

      mode_in = mode_nx;
      if (req_stream_end) begin
         // close an open token at end of stream
         if (mode_nx == MODE_SLASH) begin
            bun.data[0] = CH_SLASH;
            bun.kind[1] = KIND_END;
            bun.cnt = CNT_W'(2);
         end else if (mode_nx == MODE_TOKEN) begin
            if (bun.cnt == CNT_W'(1)) begin
               bun.kind[1] = KIND_END;
               bun.cnt = CNT_W'(2);
            end else begin
               bun.kind[2] = KIND_END;
               bun.cnt = CNT_W'(3);
            end
         end
         mode_in = MODE_IDLE;
      end
   end

   assign push = take && (bun.cnt != '0);
   assign push_bundle = bun;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (take) begin
         mode_ff <= mode_in;
      end
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("push into full queue");

   a_end_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (take && req_stream_end) |=> (mode_ff == MODE_IDLE))
      else $error("mode not idle after stream end");

   a_token_close: assert property (@(posedge clock) disable iff (reset)
      (take && (mode_ff == MODE_TOKEN) && white) |-> (push && push_bundle.kind[0] == KIND_END))
      else $error("token not closed by whitespace");

endmodule

// ===== hw/rtl/cst_queue.sv =====
// Short queue of result bundles between the front and back ends.
// Depends on cst_pkg.
module cst_queue #(
   parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cst_pkg::bundle_type push_bundle,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output cst_pkg::bundle_type head
);
   import cst_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

   bundle_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign full = (fill_ff == FILL_MAX);
   assign empty = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("queue fill out of range");

   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (fill_ff == $past(fill_ff) + FILL_W'(1)))
      else $error("queue fill did not advance on push");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      empty |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("pointers differ while queue empty");

endmodule

// ===== hw/rtl/cst_back.sv =====
// Back end of the tokenizer: walks the head bundle of the queue and
// presents one result per transaction. Depends on cst_pkg.
module cst_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  cst_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_result_kind,
   output logic [7:0]          rsp_token_byte,
   output logic                rsp_run_last
);
   import cst_pkg::*;

   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [1:0] sel;
   logic take;

   assign sel = idx_ff[1:0];
   assign rsp_valid = !empty;
   assign rsp_result_kind = head.kind[sel];
   assign rsp_token_byte = head.data[sel];
   assign rsp_run_last = ((idx_ff + CNT_W'(1)) == head.cnt);
   assign take = rsp_valid && rsp_ready;
   assign pop = take && rsp_run_last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = rsp_run_last ? '0 : idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < head.cnt))
      else $error("result index beyond bundle");

   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (idx_ff == '0))
      else $error("result index not cleared while queue empty");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_END) |-> (rsp_token_byte == 8'h00))
      else $error("token end mark carries a byte");

endmodule

// ===== hw/rtl/comment_skipping_tokenizer.sv =====
// Top level of the comment skipping tokenizer: front end, bundle queue
// and back end. Depends on cst_pkg, cst_front, cst_queue and cst_back.
//
// Usage:
//   req channel: one text byte per transaction with req_stream_end on the
//   final byte of a stream. Whitespace (0x01..0x20), line comments ending
//   at CR plus the byte after it, and block comments between tokens are
//   dropped.
//   rsp channel: token bytes (kind 0) and token end marks (kind 1);
//   rsp_run_last flags the last result caused by one input byte. A byte
//   that causes nothing produces no transaction.
//   Results enter the queue when their byte is taken; rsp shows the queue head.
//   Throughput: one byte per cycle while the queue has room; the back end
//   delivers one result per cycle while rsp_ready is high; the bundle of a byte
//   with two or three results (a lone slash, end of stream) stays until all are taken.
//   Stall: while rsp_ready is low the queue of QUEUE_DEPTH bundles keeps
//   taking bytes; req_ready drops only when it is full.
//   Reset: the lexer returns to between tokens and the queue empties.
module comment_skipping_tokenizer #(
   parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_stream_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_run_last
);
   import cst_pkg::*;

   bundle_type push_bundle, head;
   logic push, pop, full, empty;

   cst_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .req_stream_end (req_stream_end),
      .queue_full     (full),
      .push           (push),
      .push_bundle    (push_bundle)
   );

   cst_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (full),
      .empty       (empty),
      .head        (head)
   );

   cst_back u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_token_byte  (rsp_token_byte),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

// ===== sim/tb.sv =====
// Testbench for comment_skipping_tokenizer: directed table then random text streams,
// every result checked against the table's expected results (typed rows) or else an
// in-bench lexer model. Depends on cst_pkg and the top level only.
`timescale 1ns / 100ps

module tb;
   import cst_pkg::*;

   typedef struct packed {
      logic       kind;
      logic [7:0] tbyte;
      logic       run_last;
   } token_result_type;

   typedef struct packed {
      logic [1:0]                 cnt;
      token_result_type [0:2]     res;
   } result_set_type;

   typedef struct packed {
      logic [7:0]     text;
      logic           fin;
      logic           typed;
      result_set_type want;
   } stim_item_type;

   localparam token_result_type NO_RES = '0;
   localparam result_set_type NO_SET = '0;
   localparam int DIR_ROWS = 28;
   localparam int RANDOM_TOKEN_BYTES = 66;

   localparam stim_item_type DIR_TABLE [DIR_ROWS] = '{
      '{8'h41, 1'b0, 1'b1, '{2'd1, '{'{KIND_BYTE, 8'h41, 1'b1}, NO_RES, NO_RES}}},
      '{8'hFF, 1'b0, 1'b1, '{2'd1, '{'{KIND_BYTE, 8'hFF, 1'b1}, NO_RES, NO_RES}}},
      '{8'h20, 1'b0, 1'b1, '{2'd1, '{'{KIND_END, 8'h00, 1'b1}, NO_RES, NO_RES}}},
      '{8'h01, 1'b0, 1'b1, NO_SET},
      '{8'h21, 1'b1, 1'b1, '{2'd2, '{'{KIND_BYTE, 8'h21, 1'b0},
                                    '{KIND_END, 8'h00, 1'b1}, NO_RES}}},
      '{8'h2F, 1'b0, 1'b1, NO_SET},
      '{8'h78, 1'b0, 1'b0, NO_SET},
      '{8'h2F, 1'b0, 1'b0, NO_SET},
      '{8'h2A, 1'b1, 1'b0, NO_SET},
      '{8'h2F, 1'b0, 1'b0, NO_SET},
      '{8'h20, 1'b0, 1'b0, NO_SET},
      '{8'h2F, 1'b0, 1'b0, NO_SET},
      '{8'h2F, 1'b0, 1'b0, NO_SET},
      '{8'h0D, 1'b0, 1'b0, NO_SET},
      '{8'h41, 1'b0, 1'b0, NO_SET},
      '{8'h09, 1'b0, 1'b0, NO_SET},
      '{8'h2F, 1'b0, 1'b0, NO_SET},
      '{8'h2A, 1'b0, 1'b0, NO_SET},
      '{8'h2A, 1'b0, 1'b0, NO_SET},
      '{8'h2A, 1'b0, 1'b0, NO_SET},
      '{8'h2F, 1'b0, 1'b0, NO_SET},
      '{8'h0A, 1'b0, 1'b0, NO_SET},
      '{8'h2F, 1'b1, 1'b0, NO_SET},
      '{8'h2F, 1'b0, 1'b0, NO_SET},
      '{8'h2A, 1'b1, 1'b0, NO_SET},
      '{8'h2F, 1'b0, 1'b0, NO_SET},
      '{8'h2F, 1'b0, 1'b0, NO_SET},
      '{8'h0D, 1'b1, 1'b0, NO_SET}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte = 8'h20;
   logic       req_stream_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_result_kind;
   logic [7:0] rsp_token_byte;
   logic       rsp_run_last;

   mode_type         lex_mode = MODE_IDLE;
   stim_item_type    stim_q[$];
   stim_item_type    cur_item = '0;
   token_result_type due_results[$];
   int               bad_results = 0;
   logic [7:0]       rx_tick = 8'h00;

   comment_skipping_tokenizer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_stream_end  (req_stream_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_token_byte  (rsp_token_byte),
      .rsp_run_last    (rsp_run_last)
   );

   always #5 clock = ~clock;

   function automatic result_set_type with_result(result_set_type rs, logic kind,
                                                  logic [7:0] b);
      result_set_type r;
      r = rs;
      r.res[r.cnt] = '{kind, b, 1'b0};
      r.cnt = r.cnt + 2'd1;
      return r;
   endfunction

   function automatic result_set_type lex_step(input logic [7:0] c, input logic fin);
      result_set_type rs;
      logic           white;
      rs = NO_SET;
      white = (c >= 8'h01) && (c <= WHITE_MAX);
      case (lex_mode)
         MODE_IDLE: begin
            if (c == CH_SLASH) begin
               lex_mode = MODE_SLASH;
            end else if (!white) begin
               rs = with_result(rs, KIND_BYTE, c);
               lex_mode = MODE_TOKEN;
            end
         end
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               lex_mode = MODE_LINE;
            end else if (c == CH_STAR) begin
               lex_mode = MODE_BLOCK;
            end else begin
               rs = with_result(rs, KIND_BYTE, CH_SLASH);
               if (white) begin
                  rs = with_result(rs, KIND_END, 8'h00);
                  lex_mode = MODE_IDLE;
               end else begin
                  rs = with_result(rs, KIND_BYTE, c);
                  lex_mode = MODE_TOKEN;
               end
            end
         end
         MODE_TOKEN: begin
            if (white) begin
               rs = with_result(rs, KIND_END, 8'h00);
               lex_mode = MODE_IDLE;
            end else begin
               rs = with_result(rs, KIND_BYTE, c);
            end
         end
         MODE_LINE: begin
            if (c == CH_CR) lex_mode = MODE_LINE_CR;
         end
         MODE_LINE_CR: lex_mode = MODE_IDLE;
         MODE_BLOCK: begin
            if (c == CH_STAR) lex_mode = MODE_BLOCK_STAR;
         end
         MODE_BLOCK_STAR: begin
            if (c == CH_SLASH) lex_mode = MODE_IDLE;
            else if (c != CH_STAR) lex_mode = MODE_BLOCK;
         end
         default: lex_mode = MODE_IDLE;
      endcase
      if (fin) begin
         if (lex_mode == MODE_SLASH) begin
            rs = with_result(rs, KIND_BYTE, CH_SLASH);
            rs = with_result(rs, KIND_END, 8'h00);
         end else if (lex_mode == MODE_TOKEN) begin
            rs = with_result(rs, KIND_END, 8'h00);
         end
         lex_mode = MODE_IDLE;
      end
      if (rs.cnt != 2'd0) rs.res[rs.cnt - 2'd1].run_last = 1'b1;
      return rs;
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] white_byte();
      return 8'($urandom_range(1, 32));
   endfunction

   function automatic logic [7:0] token_char();
      logic [7:0] c;
      c = 8'($urandom_range(33, 255));
      if ($urandom_range(0, 5) == 0) c = ($urandom_range(0, 1) != 0) ? CH_SLASH : CH_STAR;
      return c;
   endfunction

   task automatic queue_byte(input logic [7:0] c, input logic fin);
      stim_item_type it;
      it = '{c, fin, 1'b0, NO_SET};
      stim_q.push_back(it);
   endtask

   task automatic mark_stream_end();
      stim_item_type it;
      it = stim_q[stim_q.size() - 1];
      it.fin = 1'b1;
      stim_q[stim_q.size() - 1] = it;
   endtask

   task automatic build_random_stream();
      int         counted;
      int         len;
      logic [7:0] c;
      counted = 0;
      while (counted < RANDOM_TOKEN_BYTES) begin
         case ($urandom_range(0, 8))
            0, 1, 2, 3: begin
               len = $urandom_range(1, 8);
               c = token_char();
               if (c == CH_SLASH) c = CH_STAR;
               queue_byte(c, 1'b0);
               for (int i = 1; i < len; i++) queue_byte(token_char(), 1'b0);
               counted += len;
               if ($urandom_range(0, 7) == 0) mark_stream_end();
               else repeat ($urandom_range(1, 3)) queue_byte(white_byte(), 1'b0);
            end
            4: begin
               queue_byte(CH_SLASH, 1'b0);
               queue_byte(CH_SLASH, 1'b0);
               repeat ($urandom_range(0, 6)) begin
                  c = any_byte();
                  if (c == CH_CR) c = CH_STAR;
                  queue_byte(c, 1'b0);
               end
               if ($urandom_range(0, 5) == 0) begin
                  queue_byte(CH_CR, 1'b1);
               end else begin
                  queue_byte(CH_CR, 1'b0);
                  queue_byte(($urandom_range(0, 3) == 0) ? any_byte() : 8'h0A, 1'b0);
               end
            end
            5: begin
               queue_byte(CH_SLASH, 1'b0);
               queue_byte(CH_STAR, 1'b0);
               repeat ($urandom_range(0, 8)) begin
                  c = ($urandom_range(0, 3) == 0) ? CH_STAR : any_byte();
                  if (c == CH_SLASH) c = 8'h2E;
                  queue_byte(c, 1'b0);
               end
               if ($urandom_range(0, 5) == 0) begin
                  mark_stream_end();
               end else begin
                  repeat ($urandom_range(1, 2)) queue_byte(CH_STAR, 1'b0);
                  queue_byte(CH_SLASH, 1'b0);
               end
            end
            6: begin
               queue_byte(CH_SLASH, 1'b0);
               counted += 1;
               case ($urandom_range(0, 2))
                  0: queue_byte(white_byte(), 1'b0);
                  1: begin
                     queue_byte(8'($urandom_range(48, 255)), 1'b0);
                     queue_byte(white_byte(), 1'b0);
                     counted += 1;
                  end
                  default: mark_stream_end();
               endcase
            end
            7: repeat ($urandom_range(1, 4)) queue_byte(white_byte(), 1'b0);
            default: begin
               len = $urandom_range(1, 4);
               repeat (len) queue_byte(any_byte(), 1'b0);
               counted += len;
               if ($urandom_range(0, 3) == 0) mark_stream_end();
            end
         endcase
      end
      mark_stream_end();
   endtask

   task automatic drive_stream();
      int burst;
      burst = 0;
      while (stim_q.size() != 0) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(negedge clock);
            end
         end
         cur_item = stim_q.pop_front();
         req_valid <= 1'b1;
         req_text_byte <= cur_item.text;
         req_stream_end <= cur_item.fin;
         burst--;
         do @(posedge clock); while (!req_ready);
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   // stall pattern: free, coin flip, three in four, rare
   always @(negedge clock) begin
      rx_tick <= rx_tick + 8'd1;
      case (rx_tick[7:6])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 1) != 0);
         2'd2: rsp_ready <= (rx_tick[1:0] == 2'd0);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin : score
      result_set_type   made;
      token_result_type got;
      token_result_type want;
      if (reset) begin
         lex_mode = MODE_IDLE;
      end else begin
         if (req_valid && req_ready) begin
            made = lex_step(req_text_byte, req_stream_end);
            if (cur_item.typed) made = cur_item.want;
            for (int i = 0; i < 3; i++) begin
               if (i < made.cnt) due_results.push_back(made.res[i]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_result_kind, rsp_token_byte, rsp_run_last};
            if (due_results.size() == 0) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("unexpected transaction: kind=%0d byte=%02h last=%0d",
                           got.kind, got.tbyte, got.run_last);
            end else begin
               want = due_results.pop_front();
               if (got !== want) begin
                  bad_results++;
                  if (bad_results <= 10)
                     $display("mismatch: kind %0d/%0d byte %02h/%02h last %0d/%0d (exp/got)",
                              want.kind, got.kind, want.tbyte, got.tbyte,
                              want.run_last, got.run_last);
               end
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < DIR_ROWS; i++) stim_q.push_back(DIR_TABLE[i]);
      build_random_stream();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      drive_stream();
      while (due_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (bad_results == 0 && due_results.size() == 0) begin
         $display("[comment_skipping_tokenizer] OK");
      end else begin
         $display("[comment_skipping_tokenizer] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[comment_skipping_tokenizer] ERROR");
      $finish;
   end

endmodule
